FILE: sv/jsli_pkg.sv
`timescale 1ns / 1ps
package jsli_pkg;

  localparam int NUM_JOINTS = 10;
  localparam int JW = $clog2(NUM_JOINTS);

  localparam logic [2:0] REG_VEL_FIRST  = 3'd0;
  localparam logic [2:0] REG_VEL_SECOND = 3'd1;
  localparam logic [2:0] REG_VEL_THIRD  = 3'd2;
  localparam logic [2:0] REG_VEL_OTHER  = 3'd3;
  localparam logic [2:0] REG_SAMPLE     = 3'd4;

  localparam logic [31:0] TIME_MAX  = 32'hFFFF_FFFF;
  localparam logic [31:0] US_PER_S  = 32'd1000000;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic          accept_load;
    logic          accept_tick;
    logic          copy;
    logic          commit;
    logic          seg_trivial;
    logic          unit_start;
    logic          unit_seg;
    logic          seg_fold;
    logic          set_dur;
    logic          load_out;
    logic [JW-1:0] joint;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mag_zero;
    logic vel_zero;
    logic unit_done;
    logic tick_done;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_COPY      = 9'b000000010,
    ST_SEG       = 9'b000000100,
    ST_SEG_WAIT  = 9'b000001000,
    ST_SEG_END   = 9'b000010000,
    ST_TICK      = 9'b000100000,
    ST_TICK_WAIT = 9'b001000000,
    ST_EMIT      = 9'b010000000,
    ST_SPARE     = 9'b100000000
  } state_t;

endpackage

FILE: sv/jsli_muldiv.sv
`timescale 1ns / 1ps
module jsli_muldiv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] a,
  input  logic [31:0] b,
  input  logic [31:0] d,
  output logic        done,
  output logic [64:0] quo,
  output logic        rem_nz
);

  logic        busy_r, busy_nxt;
  logic        div_r, div_nxt;
  logic        done_r, done_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [64:0] acc_r, acc_nxt;
  logic [64:0] ash_r, ash_nxt;
  logic [31:0] bsh_r, bsh_nxt;
  logic [31:0] d_r, d_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [32:0] rem_sh;
  logic [32:0] rem_diff;
  logic        ge;

  assign rem_sh   = {rem_r, acc_r[64]};
  assign ge       = rem_sh >= {1'b0, d_r};
  assign rem_diff = rem_sh - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    div_nxt  = div_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    ash_nxt  = ash_r;
    bsh_nxt  = bsh_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      div_nxt  = 1'b0;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      ash_nxt  = {32'd0, a};
      bsh_nxt  = b;
      d_nxt    = d;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (!div_r) begin
        // shift-add multiply, one multiplier bit a cycle
        if (bsh_r[0]) begin
          acc_nxt = acc_r + ash_r;
        end
        ash_nxt = {ash_r[63:0], 1'b0};
        bsh_nxt = {1'b0, bsh_r[31:1]};
        if (cnt_r == 7'd31) begin
          div_nxt = 1'b1;
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end else begin
        // restoring divide of the product, one quotient bit a cycle
        rem_nxt = ge ? rem_diff[31:0] : rem_sh[31:0];
        acc_nxt = {acc_r[63:0], ge};
        if (cnt_r == 7'd64) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      div_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      div_r  <= div_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    ash_r <= ash_nxt;
    bsh_r <= bsh_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

  assign done   = done_r;
  assign quo    = acc_r;
  assign rem_nz = |rem_r;

endmodule

FILE: sv/jsli_dp.sv
`timescale 1ns / 1ps
module jsli_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  jsli_pkg::ctrl_cmd_t cmd,
  output jsli_pkg::dp_stat_t  stat,
  input  logic [3:0]          in_joint_number,
  input  logic [31:0]         in_joint_angle,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [19:0]         cfg_data,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [3:0]          out_joint,
  output logic [31:0]         out_angle,
  output logic                out_last_joint,
  output logic                out_segment_done,
  output logic [15:0]         out_segment_number,
  output logic [15:0]         out_sample_number
);

  localparam int N  = jsli_pkg::NUM_JOINTS;
  localparam int JW = jsli_pkg::JW;

  logic [15:0] vel_first_r, vel_second_r, vel_third_r, vel_other_r;
  logic [19:0] sample_period_r;
  logic [31:0] staged_r [N];
  logic [31:0] start_r  [N];
  logic [31:0] target_r [N];
  logic [31:0] dur_r, elapsed_r, best_r, t_r;
  logic [1:0]  seen_r;
  logic [15:0] seg_cnt_r, samp_cnt_r, seg_l_r, samp_l_r;
  logic        tick_done_r;
  logic        out_valid_r;
  logic [3:0]  out_joint_r;
  logic [31:0] out_angle_r;
  logic        out_last_r;
  logic        out_done_r;
  logic [15:0] out_seg_r, out_samp_r;

  logic [31:0] s, tg;
  logic [32:0] delta, mag;
  logic        neg;
  logic [15:0] vel;
  logic [31:0] unit_b, unit_d;
  logic        unit_done, rem_nz;
  logic [64:0] quo;
  logic [32:0] sum33;
  logic [31:0] t_sat;
  logic [32:0] sres;
  logic [31:0] emit_val;
  logic        at_end;
  logic [32:0] el_sum;
  logic [19:0] step;

  assign s     = start_r[cmd.joint];
  assign tg    = target_r[cmd.joint];
  assign delta = {tg[31], tg} - {s[31], s};
  assign neg   = delta[32];
  assign mag   = neg ? (33'd0 - delta) : delta;

  always_comb begin
    case (cmd.joint)
      JW'(0):  vel = vel_first_r;
      JW'(1):  vel = vel_second_r;
      JW'(2):  vel = vel_third_r;
      default: vel = vel_other_r;
    endcase
  end

  assign unit_b = cmd.unit_seg ? jsli_pkg::US_PER_S : t_r;
  assign unit_d = cmd.unit_seg ? {8'd0, vel, 8'd0} : dur_r;

  jsli_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.unit_start),
    .a      (mag),
    .b      (unit_b),
    .d      (unit_d),
    .done   (unit_done),
    .quo    (quo),
    .rem_nz (rem_nz)
  );

  // ceiling of the joint time, saturated to 32 bits
  assign sum33 = {1'b0, quo[31:0]} + {32'd0, rem_nz};
  assign t_sat = ((|quo[64:32]) || sum33[32]) ? jsli_pkg::TIME_MAX : sum33[31:0];

  assign sres     = neg ? ({s[31], s} - quo[32:0]) : ({s[31], s} + quo[32:0]);
  assign emit_val = tick_done_r ? tg : sres[31:0];

  assign at_end = elapsed_r >= dur_r;
  assign step   = (sample_period_r == 20'd0) ? 20'd1 : sample_period_r;
  assign el_sum = {1'b0, elapsed_r} + {13'd0, step};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_first_r     <= 16'd5120;
      vel_second_r    <= 16'd4352;
      vel_third_r     <= 16'd4352;
      vel_other_r     <= 16'd10240;
      sample_period_r <= 20'd10000;
      for (int i = 0; i < N; i++) begin
        start_r[i]  <= '0;
        target_r[i] <= '0;
      end
      dur_r       <= '0;
      elapsed_r   <= '0;
      seen_r      <= '0;
      seg_cnt_r   <= '0;
      samp_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          jsli_pkg::REG_VEL_FIRST:  vel_first_r     <= cfg_data[15:0];
          jsli_pkg::REG_VEL_SECOND: vel_second_r    <= cfg_data[15:0];
          jsli_pkg::REG_VEL_THIRD:  vel_third_r     <= cfg_data[15:0];
          jsli_pkg::REG_VEL_OTHER:  vel_other_r     <= cfg_data[15:0];
          jsli_pkg::REG_SAMPLE:     sample_period_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.copy) begin
        start_r[cmd.joint]  <= (seen_r == 2'd0) ? staged_r[cmd.joint] : target_r[cmd.joint];
        target_r[cmd.joint] <= staged_r[cmd.joint];
      end
      if (cmd.commit) begin
        if (seen_r != 2'd0) begin
          seg_cnt_r <= seg_cnt_r + 16'd1;
        end
        if (seen_r != 2'd2) begin
          seen_r <= seen_r + 2'd1;
        end
        elapsed_r  <= '0;
        samp_cnt_r <= '0;
      end
      if (cmd.set_dur) begin
        dur_r <= best_r;
      end
      if (cmd.accept_tick) begin
        if (!at_end) begin
          elapsed_r <= el_sum[32] ? jsli_pkg::TIME_MAX : el_sum[31:0];
        end
        if (samp_cnt_r != jsli_pkg::COUNT_MAX) begin
          samp_cnt_r <= samp_cnt_r + 16'd1;
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_load && ({1'b0, in_joint_number} < 5'(N))) begin
      staged_r[in_joint_number[JW-1:0]] <= in_joint_angle;
    end
    if (cmd.commit) begin
      best_r <= '0;
    end else if (cmd.seg_trivial) begin
      // a moving joint with no velocity limit takes forever
      if (mag != 33'd0) begin
        best_r <= jsli_pkg::TIME_MAX;
      end
    end else if (cmd.seg_fold && (t_sat > best_r)) begin
      best_r <= t_sat;
    end
    if (cmd.accept_tick) begin
      tick_done_r <= at_end;
      t_r         <= elapsed_r;
      seg_l_r     <= seg_cnt_r;
      samp_l_r    <= samp_cnt_r;
    end
    if (cmd.load_out) begin
      out_joint_r <= 4'(cmd.joint);
      out_angle_r <= emit_val;
      out_last_r  <= cmd.joint == JW'(N - 1);
      out_done_r  <= tick_done_r;
      out_seg_r   <= seg_l_r;
      out_samp_r  <= samp_l_r;
    end
  end

  assign stat.mag_zero  = mag == 33'd0;
  assign stat.vel_zero  = vel == 16'd0;
  assign stat.unit_done = unit_done;
  assign stat.tick_done = tick_done_r;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_joint          = out_joint_r;
  assign out_angle          = out_angle_r;
  assign out_last_joint     = out_last_r;
  assign out_segment_done   = out_done_r;
  assign out_segment_number = out_seg_r;
  assign out_sample_number  = out_samp_r;

endmodule

FILE: sv/jsli_ctrl.sv
`timescale 1ns / 1ps
module jsli_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_action,
  input  logic                in_waypoint_complete,
  input  jsli_pkg::dp_stat_t  stat,
  output jsli_pkg::ctrl_cmd_t cmd
);

  localparam int JW = jsli_pkg::JW;

  jsli_pkg::state_t state_r, state_nxt;
  logic [JW-1:0]    j_r, j_nxt;
  logic             accept, last;

  assign in_ready = state_r == jsli_pkg::ST_IDLE;
  assign accept   = in_valid && in_ready;
  assign last     = j_r == JW'(jsli_pkg::NUM_JOINTS - 1);

  always_comb begin
    state_nxt       = state_r;
    j_nxt           = j_r;
    cmd             = '0;
    cmd.joint       = j_r;
    cmd.accept_load = accept && !in_action;
    cmd.accept_tick = accept && in_action;
    case (state_r)
      jsli_pkg::ST_IDLE: begin
        j_nxt = '0;
        if (accept) begin
          if (in_action) begin
            state_nxt = jsli_pkg::ST_TICK;
          end else if (in_waypoint_complete) begin
            state_nxt = jsli_pkg::ST_COPY;
          end
        end
      end
      jsli_pkg::ST_COPY: begin
        cmd.copy = 1'b1;
        if (last) begin
          cmd.commit = 1'b1;
          j_nxt      = '0;
          state_nxt  = jsli_pkg::ST_SEG;
        end else begin
          j_nxt = j_r + JW'(1);
        end
      end
      jsli_pkg::ST_SEG: begin
        if (stat.mag_zero || stat.vel_zero) begin
          cmd.seg_trivial = 1'b1;
          if (last) begin
            state_nxt = jsli_pkg::ST_SEG_END;
          end else begin
            j_nxt = j_r + JW'(1);
          end
        end else begin
          cmd.unit_start = 1'b1;
          cmd.unit_seg   = 1'b1;
          state_nxt      = jsli_pkg::ST_SEG_WAIT;
        end
      end
      jsli_pkg::ST_SEG_WAIT: begin
        if (stat.unit_done) begin
          cmd.seg_fold = 1'b1;
          if (last) begin
            state_nxt = jsli_pkg::ST_SEG_END;
          end else begin
            j_nxt     = j_r + JW'(1);
            state_nxt = jsli_pkg::ST_SEG;
          end
        end
      end
      jsli_pkg::ST_SEG_END: begin
        cmd.set_dur = 1'b1;
        state_nxt   = jsli_pkg::ST_IDLE;
      end
      jsli_pkg::ST_TICK: begin
        if (stat.tick_done) begin
          state_nxt = jsli_pkg::ST_EMIT;
        end else begin
          cmd.unit_start = 1'b1;
          state_nxt      = jsli_pkg::ST_TICK_WAIT;
        end
      end
      jsli_pkg::ST_TICK_WAIT: begin
        if (stat.unit_done) begin
          state_nxt = jsli_pkg::ST_EMIT;
        end
      end
      jsli_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          if (last) begin
            state_nxt = jsli_pkg::ST_IDLE;
          end else begin
            j_nxt     = j_r + JW'(1);
            state_nxt = jsli_pkg::ST_TICK;
          end
        end
      end
      default: begin
        state_nxt = jsli_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jsli_pkg::ST_IDLE;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
    end
  end

endmodule

FILE: sv/joint_space_linear_interpolator_top.sv
`timescale 1ns / 1ps
// Linear joint-space interpolator for ten joints. A load of one coordinate leaves the
// block idle and ready for the next item. A load that completes a waypoint copies the ten
// staged angles, then finds a time for each joint that moves and keeps the longest as the
// segment duration. A tick emits ten words, one per joint in order; while the segment is
// running each word needs a pass through the multiplier and divider, none once the target
// is reached, and an output stall holds the next word. One shared shift-add multiplier and
// restoring divider does both jobs. One item is worked on at a time; the output word register
// lets the last word of a tick wait while the next item is taken.
module joint_space_linear_interpolator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [3:0]  in_joint_number,
  input  logic [31:0] in_joint_angle,
  input  logic        in_waypoint_complete,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_joint,
  output logic [31:0] out_angle,
  output logic        out_last_joint,
  output logic        out_segment_done,
  output logic [15:0] out_segment_number,
  output logic [15:0] out_sample_number,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  jsli_pkg::ctrl_cmd_t cmd;
  jsli_pkg::dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  jsli_ctrl u_ctrl (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_action            (in_action),
    .in_waypoint_complete (in_waypoint_complete),
    .stat                 (stat),
    .cmd                  (cmd)
  );

  jsli_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_joint_number    (in_joint_number),
    .in_joint_angle     (in_joint_angle),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_joint          (out_joint),
    .out_angle          (out_angle),
    .out_last_joint     (out_last_joint),
    .out_segment_done   (out_segment_done),
    .out_segment_number (out_segment_number),
    .out_sample_number  (out_sample_number)
  );

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_action) |=> !in_ready)
    else $error("tick accepted but block still ready");

  a_joint_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=>
      (!out_valid || out_joint == $past(out_joint) + 4'd1 || out_joint == 4'd0))
    else $error("joint words out of order");

  a_last_joint: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_joint) |-> out_joint == 4'(jsli_pkg::NUM_JOINTS - 1))
    else $error("last joint flag on wrong joint");

endmodule
